/* src/format_integer_ascii_macros.svh */
// Assertion macros used by the formatter back end (fia_back).
// Needs a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef FORMAT_INTEGER_ASCII_MACROS_SVH
`define FORMAT_INTEGER_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/fia_pkg.sv */
// Shared types and constants for the integer-to-ASCII formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fia_pkg;

  // Field buffer size; at most one less is emitted.
  localparam int FIELD_CHARS = 16;
  localparam int MAX_CHARS   = FIELD_CHARS - 1;
  localparam int CNT_W       = $clog2(FIELD_CHARS);

  // Longest digit string of a 32-bit value (decimal).
  localparam int DIG_MAX   = 10;
  localparam int DIG_IDX_W = $clog2(DIG_MAX);
  localparam int DIG_CNT_W = $clog2(DIG_MAX + 1);

  // Reciprocal of ten: q = (v * RECIP_10) >> RECIP_SHIFT is exact for 32-bit v.
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPA   = 8'h41;

  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_CHAR = 2'd3
  } mode_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic        raw;
    logic        hex;
    logic        neg;
    logic        zpad;
    logic [3:0]  width;
    logic [31:0] mag;
  } cmd_t;

endpackage

/* src/fia_front.sv */
// Front end: accepts input transactions and classifies them into commands.
// Depends on fia_pkg.
`timescale 1ns / 1ps

module fia_front
  import fia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [31:0] value,
  input  logic        zero_pad,
  input  logic [3:0]  width,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_ready
);

  logic fv;
  cmd_t fcmd;
  cmd_t cls;
  logic accept;

  always_comb begin
    cls.raw   = (mode_t'(mode) == MODE_CHAR);
    cls.hex   = (mode_t'(mode) == MODE_HEX);
    cls.neg   = (mode_t'(mode) == MODE_SDEC) && value[31];
    cls.zpad  = zero_pad;
    cls.width = width;
    // Negate modulo 2^32; the most negative value maps to itself.
    cls.mag   = cls.neg ? (32'd0 - value) : value;
  end

  assign full      = fv && !cmd_ready;
  assign accept    = push && !full;
  assign cmd       = fcmd;
  assign cmd_valid = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= accept || (fv && !cmd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fcmd <= cls;
    end
  end

endmodule

/* src/fia_queue.sv */
// Two-entry command queue between front and back.
// Depends on fia_pkg.
`timescale 1ns / 1ps

module fia_queue
  import fia_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t in_cmd,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t out_cmd,
  output logic out_valid,
  input  logic out_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* src/fia_back.sv */
// Back end: digit extraction, padding and character output register.
// Depends on fia_pkg and format_integer_ascii_macros.svh.
`timescale 1ns / 1ps
`include "format_integer_ascii_macros.svh"

module fia_back
  import fia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  output logic [7:0] char_out,
  output logic       last,
  output logic       empty,
  input  logic       pop
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  back_state_t          state;
  logic [31:0]          mag;
  logic                 hex;
  logic                 zpad;
  logic [3:0]           width;
  logic                 neg_left;
  logic [CNT_W-1:0]     pad_left;
  logic [DIG_CNT_W-1:0] dcnt;
  logic [7:0]           digits [DIG_MAX];
  logic                 ov;
  logic [7:0]           oc;
  logic                 ol;

  logic [63:0]          prod;
  logic [31:0]          quo;
  logic [31:0]          rem_full;
  logic [3:0]           dig;
  logic [7:0]           dig_ch;
  logic [31:0]          mag_next;
  logic [CNT_W-1:0]     len;
  logic [CNT_W-1:0]     wcap;
  logic [CNT_W:0]       remaining;
  logic                 emit_load;

  // Divide by ten through the reciprocal, remainder by shift-add; hex takes the low nibble instead.
  assign prod     = 64'(mag) * 64'(RECIP_10);
  assign quo      = 32'(prod[63:RECIP_SHIFT]);
  assign rem_full = mag - ((quo << 3) + (quo << 1));
  assign dig      = hex ? mag[3:0] : rem_full[3:0];
  assign dig_ch   = (dig > 4'd9) ? (CH_UPA + 8'(dig) - 8'd10) : (CH_ZERO + 8'(dig));
  assign mag_next = hex ? (mag >> 4) : quo;

  // Field length once this digit is in: digits plus a sign.
  assign len  = CNT_W'(dcnt) + CNT_W'(1) + CNT_W'(neg_left);
  assign wcap = (CNT_W'(width) > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : CNT_W'(width);

  assign remaining = (CNT_W + 1)'(pad_left) + (CNT_W + 1)'(neg_left) + (CNT_W + 1)'(dcnt);
  assign emit_load = (state == ST_EMIT) && (!ov || pop);

  assign cmd_ready = (state == ST_LOAD);
  assign empty     = !ov;
  assign char_out  = oc;
  assign last      = ol;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      ov    <= 1'b0;
    end else begin
      ov <= emit_load || (ov && !pop);
      case (state)
        ST_LOAD: begin
          if (cmd_valid) state <= cmd.raw ? ST_EMIT : ST_CONV;
        end
        ST_CONV: begin
          if (mag_next == 32'd0) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load && remaining == (CNT_W + 1)'(1)) state <= ST_LOAD;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (cmd_valid) begin
          mag   <= cmd.mag;
          hex   <= cmd.hex;
          zpad  <= cmd.zpad;
          width <= cmd.width;
          if (cmd.raw) begin
            // Raw byte rides the digit stack as a single entry.
            digits[0] <= cmd.mag[7:0];
            dcnt      <= DIG_CNT_W'(1);
            neg_left  <= 1'b0;
            pad_left  <= '0;
          end else begin
            dcnt     <= '0;
            neg_left <= cmd.neg;
          end
        end
      end
      ST_CONV: begin
        digits[dcnt[DIG_IDX_W-1:0]] <= dig_ch;
        dcnt <= dcnt + DIG_CNT_W'(1);
        mag  <= mag_next;
        if (mag_next == 32'd0) begin
          pad_left <= (wcap > len) ? (wcap - len) : '0;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          ol <= (remaining == (CNT_W + 1)'(1));
          if (pad_left != '0) begin
            oc       <= zpad ? CH_ZERO : CH_SPACE;
            pad_left <= pad_left - CNT_W'(1);
          end else if (neg_left) begin
            oc       <= CH_MINUS;
            neg_left <= 1'b0;
          end else begin
            oc   <= digits[DIG_IDX_W'(dcnt - DIG_CNT_W'(1))];
            dcnt <= dcnt - DIG_CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  `FIA_ASSERT_NOW(a_conv_room, state == ST_CONV, dcnt < DIG_CNT_W'(DIG_MAX), "digit stack overflow")
  `FIA_ASSERT_NOW(a_emit_work, state == ST_EMIT, remaining != '0, "emit with nothing left")
  `FIA_ASSERT_NEXT(a_last_done, emit_load && remaining == (CNT_W + 1)'(1), state == ST_LOAD && ol && ov, "last character did not end field")
  `FIA_ASSERT_NEXT(a_raw_one, state == ST_LOAD && cmd_valid && cmd.raw, state == ST_EMIT && remaining == (CNT_W + 1)'(1), "raw field not single character")

endmodule

/* src/format_integer_ascii.sv */
// Top level of the integer-to-ASCII field formatter.
// Depends on fia_pkg, fia_front, fia_queue and fia_back.
//
// Usage:
//   Input side is a queue: drive mode, value, zero_pad and width and raise
//   push; the transaction is taken at a clock edge with push high and full
//   low. Result side is a queue too: while empty is low, char_out and last
//   show the oldest waiting character; pop takes it at an edge with empty low.
//   Each field comes out most significant character first, padding before
//   any minus sign, with last set on its final character.
// Flow:
//   Input is registered in the classify stage, then written into a
//   two-entry queue. The back end loads a command, extracts the digits one
//   at a time (multiply by the reciprocal of ten, or nibble shift), then
//   emits padding, sign and digits one character at a time through the
//   output register; a raw character skips digit extraction. The back end
//   works on one field at a time while the queue and front hold the next.
// Reset: rst is synchronous and active high; it drops queued and in-flight
//   work and leaves the block ready with empty high.
// Stall: a held result stalls character output in the back end; the queue
//   and the front keep taking transactions until both fill, then full rises.
`timescale 1ns / 1ps

module format_integer_ascii
  import fia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [31:0] value,
  input  logic        zero_pad,
  input  logic [3:0]  width,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_out,
  output logic        last
);

  // Front to queue.
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // Queue to back.
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Classify: pick radix, strip the sign, hold one command.
  fia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .value     (value),
    .zero_pad  (zero_pad),
    .width     (width),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // Decouple: let the front keep accepting while the back works.
  fia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (front_cmd),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_cmd   (back_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  // Convert: extract digits, then emit padding, sign and digits.
  fia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .char_out  (char_out),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

/* sim/format_integer_ascii_test.sv */
// Self-checking testbench for format_integer_ascii: directed table, then random fields.
// Depends on fia_pkg for the mode codes, the character constants and the field size.
`timescale 1ns / 1ps

module format_integer_ascii_test;
  import fia_pkg::*;

  // Stimulus sizes and timing.
  localparam int NUM_DIR_ROWS  = 25;
  localparam int RANDOM_ITEMS  = 435;
  localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
  localparam int HOLD_AFTER    = 60;    // characters taken before the hold-off
  localparam int DRAIN_CYCLES  = 60;    // idle cycles after the last owed character
  localparam int STYLE_CYCLES  = 50;    // cycles per receiver stall style

  // Receiver stall styles.
  localparam int POP_ALWAYS   = 0;
  localparam int POP_HALF     = 1;
  localparam int POP_SPARSE   = 2;
  localparam int POP_PERIODIC = 3;

  // Random value shapes.
  localparam int VAL_ANY      = 0;
  localparam int VAL_SMALL    = 1;
  localparam int VAL_SIGN_SET = 2;
  localparam int VAL_SMALL_NEG = 3;
  localparam int VAL_NEAR_MAX = 4;
  localparam int VAL_SHIFTED  = 5;

  // One emitted character as the block should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       last_ch;
  } field_char_t;

  // One row of the directed table. nlit is the length of the literal field
  // in txt (right aligned, first character highest); zero means predict it.
  typedef struct packed {
    mode_t        md;
    logic [31:0]  val;
    logic         zp;
    logic [3:0]   w;
    logic [3:0]   nlit;
    logic [119:0] txt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = MODE_SDEC;
  logic [31:0] value = '0;
  logic        zero_pad = 1'b0;
  logic [3:0]  width = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  char_out;
  logic        last;

  field_char_t pending_chars[$];   // characters still owed by the block, oldest first
  int errors       = 0;
  int fields_sent  = 0;
  int chars_seen   = 0;
  int full_cycles  = 0;

  format_integer_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .value    (value),
    .zero_pad (zero_pad),
    .width    (width),
    .empty    (empty),
    .pop      (pop),
    .char_out (char_out),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected character.
  function automatic void expect_char(input logic [7:0] ch, input logic last_ch);
    field_char_t fc;
    fc.ch = ch;
    fc.last_ch = last_ch;
    pending_chars.push_back(fc);
  endfunction

  // Work out the characters of one field and queue them. The field is built
  // right to left in a buffer of FIELD_CHARS - 1 usable slots: digits first,
  // then the minus sign, then the padding, each only while room is left.
  function automatic void format_field(input logic [1:0] md, input logic [31:0] val,
                                       input logic zp, input logic [3:0] w);
    logic [7:0]  field [FIELD_CHARS];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] digit;
    logic        neg;
    int          pos;
    int          floor_pos;
    if (md == MODE_CHAR) begin
      // Raw character: low byte only, width and padding play no part.
      expect_char(val[7:0], 1'b1);
      return;
    end
    radix = (md == MODE_HEX) ? 32'd16 : 32'd10;
    // Negate modulo 2^32; the most negative value maps onto itself.
    neg = (md == MODE_SDEC) && val[31];
    mag = neg ? (32'd0 - val) : val;
    pos = FIELD_CHARS - 1;
    do begin
      digit = mag % radix;
      pos--;
      field[pos] = (digit >= 32'd10) ? CH_UPA + (digit[7:0] - 8'd10) : CH_ZERO + digit[7:0];
      mag = mag / radix;
    end while (pos > 0 && mag != 32'd0);
    if (pos > 0 && neg) begin
      pos--;
      field[pos] = CH_MINUS;
    end
    // Padding lands in front of the sign, so zero padding gives 000-5.
    floor_pos = FIELD_CHARS - 1 - int'(w);
    while (pos > 0 && pos > floor_pos) begin
      pos--;
      field[pos] = zp ? CH_ZERO : CH_SPACE;
    end
    for (int k = pos; k < FIELD_CHARS - 1; k++)
      expect_char(field[k], k == FIELD_CHARS - 2);
  endfunction

  // Directed table. Literal rows are fields that can be read off directly;
  // the rest (unprintable bytes, padded fields) go through format_field.
  function automatic dir_row_t dir_row(input int r);
    case (r)
      0:  return '{MODE_CHAR, 32'h0000_0041, 1'b0, 4'd0,  4'd1,  "A"};
      1:  return '{MODE_CHAR, 32'h0000_0000, 1'b0, 4'd0,  4'd0,  "" };
      2:  return '{MODE_CHAR, 32'hFFFF_FF7E, 1'b1, 4'd15, 4'd1,  "~"};
      3:  return '{MODE_CHAR, 32'h0000_00FF, 1'b1, 4'd3,  4'd0,  "" };
      4:  return '{MODE_SDEC, 32'h0000_0000, 1'b0, 4'd0,  4'd1,  "0"};
      5:  return '{MODE_SDEC, 32'h7FFF_FFFF, 1'b0, 4'd0,  4'd10, "2147483647"};
      6:  return '{MODE_SDEC, 32'h8000_0000, 1'b0, 4'd0,  4'd11, "-2147483648"};
      7:  return '{MODE_SDEC, 32'hFFFF_FFFF, 1'b0, 4'd0,  4'd2,  "-1"};
      8:  return '{MODE_SDEC, 32'hFFFF_FFFB, 1'b1, 4'd5,  4'd5,  "000-5"};
      9:  return '{MODE_SDEC, 32'hFFFF_FFFB, 1'b0, 4'd5,  4'd5,  "   -5"};
      10: return '{MODE_UDEC, 32'hFFFF_FFFF, 1'b0, 4'd0,  4'd10, "4294967295"};
      11: return '{MODE_UDEC, 32'h0000_0000, 1'b1, 4'd15, 4'd15, "000000000000000"};
      12: return '{MODE_UDEC, 32'd42,        1'b0, 4'd15, 4'd0,  "" };
      13: return '{MODE_HEX,  32'hFFFF_FFFF, 1'b0, 4'd0,  4'd8,  "FFFFFFFF"};
      14: return '{MODE_HEX,  32'hDEAD_BEEF, 1'b1, 4'd12, 4'd12, "0000DEADBEEF"};
      15: return '{MODE_HEX,  32'h0000_0000, 1'b0, 4'd0,  4'd1,  "0"};
      16: return '{MODE_HEX,  32'h0123_ABCD, 1'b1, 4'd3,  4'd7,  "123ABCD"};
      17: return '{MODE_SDEC, 32'h8000_0000, 1'b1, 4'd15, 4'd15, "0000-2147483648"};
      18: return '{MODE_UDEC, 32'd12345,     1'b0, 4'd6,  4'd0,  "" };
      19: return '{MODE_SDEC, 32'd123,       1'b0, 4'd0,  4'd3,  "123"};
      20: return '{MODE_HEX,  32'h0000_000A, 1'b0, 4'd1,  4'd1,  "A"};
      21: return '{MODE_SDEC, 32'hFFFF_FF85, 1'b0, 4'd15, 4'd0,  "" };
      22: return '{MODE_UDEC, 32'h8000_0000, 1'b0, 4'd0,  4'd10, "2147483648"};
      23: return '{MODE_HEX,  32'h89AB_CDEF, 1'b0, 4'd9,  4'd9,  " 89ABCDEF"};
      default: return '{MODE_CHAR, 32'h8000_0030, 1'b1, 4'd7, 4'd1, "0"};
    endcase
  endfunction

  // Offer one field and hold it until the block takes it. Called at a rising
  // edge; returns at the edge where the transaction went through.
  task automatic offer(input logic [1:0] md, input logic [31:0] val,
                       input logic zp, input logic [3:0] w);
    push     <= 1'b1;
    mode     <= md;
    value    <= val;
    zero_pad <= zp;
    width    <= w;
    do @(posedge clk); while (full);
    fields_sent++;
  endtask

  // Drop push for a rest given by n. With n of zero, leave push alone so a burst
  // continues without a second assignment in the same step.
  task automatic rest(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender: reset, directed table, random bursts, then drain and report.
  initial begin
    dir_row_t    row;
    int          burst;
    int          sent_random;
    logic [1:0]  md;
    logic [31:0] val;
    logic        zp;
    logic [3:0]  w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; typed-in fields go straight into the queue.
    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      row = dir_row(r);
      offer(row.md, row.val, row.zp, row.w);
      if (row.nlit != 4'd0) begin
        for (int k = 0; k < int'(row.nlit); k++)
          expect_char(row.txt[8 * (int'(row.nlit) - 1 - k) +: 8], k == int'(row.nlit) - 1);
      end else begin
        format_field(row.md, row.val, row.zp, row.w);
      end
      rest(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
    end

    // Random fields in bursts of random length; some gaps are skipped so
    // back-to-back bursts also occur.
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent_random < RANDOM_ITEMS; b++) begin
        md = 2'($urandom_range(0, 3));
        case ($urandom_range(VAL_ANY, VAL_SHIFTED))
          VAL_ANY:       val = $urandom;
          VAL_SMALL:     val = $urandom_range(0, 99);
          VAL_SIGN_SET:  val = {1'b1, 31'($urandom)};
          VAL_SMALL_NEG: val = 32'd0 - 32'($urandom_range(1, 1000));
          VAL_NEAR_MAX:  val = 32'hFFFF_FFFF ^ 32'($urandom_range(0, 15));
          default:       val = $urandom >> $urandom_range(0, 31);
        endcase
        zp = 1'($urandom_range(0, 1));
        w  = 4'($urandom_range(0, 15));
        offer(md, val, zp, w);
        format_field(md, val, zp, w);
        sent_random++;
      end
      rest(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end
    rest(1);

    // Wait for every owed character, then give stray output time to show.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d fields (%0d from the directed table) over all four modes; %0d chars.",
             fields_sent, NUM_DIR_ROWS, chars_seen);
    $display("Input was held off by full on %0d cycles.", full_cycles);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: check each character taken, then pick the next pop. The stall
  // style is redrawn at random as the run goes on; once, early on, hold pop low for
  // a long stretch so the block backs up and raises full.
  initial begin
    field_char_t exp_char;
    int          hold_left;
    int          stall_style;
    int          cyc;
    logic        hold_done;
    hold_left   = 0;
    stall_style = POP_ALWAYS;
    cyc         = 0;
    hold_done   = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (full) full_cycles++;
      if (pop && !empty) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          $display("%0t: char with nothing expected: expected none, actual char_out %h last %b",
                   $time, char_out, last);
          errors++;
        end else begin
          exp_char = pending_chars.pop_front();
          if (char_out !== exp_char.ch) begin
            $display("%0t: char_out mismatch: expected %h, actual %h",
                     $time, exp_char.ch, char_out);
            errors++;
          end
          if (last !== exp_char.last_ch) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, exp_char.last_ch, last);
            errors++;
          end
        end
      end

      cyc++;
      if (cyc % STYLE_CYCLES == 0) stall_style = $urandom_range(POP_ALWAYS, POP_PERIODIC);
      if (!hold_done && chars_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end

      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (stall_style)
          POP_ALWAYS: pop <= 1'b1;
          POP_HALF:   pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:    pop <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
